/* hdl/btbc_pkg.sv */
`default_nettype none

package btbc_pkg;

  // Field and register widths
  localparam int unsigned CmdW     = 3;
  localparam int unsigned MsW      = 16;
  localparam int unsigned GoalW    = 8;
  localparam int unsigned BlinkW   = GoalW + 1;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  // Register reset values
  localparam logic [MsW-1:0]   DefaultOnReset  = MsW'(5 * 1000);
  localparam logic [MsW-1:0]   BlinkPauseReset = MsW'(500);
  localparam logic [GoalW-1:0] BlinkGoalReset  = GoalW'(4);

  // Register indexes
  localparam logic [CfgAddrW-1:0] REG_DEFAULT_ON  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_BLINK_PAUSE = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_BLINK_GOAL  = 2'd2;

  // Command codes
  localparam logic [CmdW-1:0] CMD_TICK       = 3'd0;
  localparam logic [CmdW-1:0] CMD_EN_DEFAULT = 3'd1;
  localparam logic [CmdW-1:0] CMD_EN_CUSTOM  = 3'd2;
  localparam logic [CmdW-1:0] CMD_BLINK_OFF  = 3'd3;
  localparam logic [CmdW-1:0] CMD_BLINK_ON   = 3'd4;

  // Mode codes as reported on the result stream
  localparam logic [ModeW-1:0] MCODE_OFF      = 3'd0;
  localparam logic [ModeW-1:0] MCODE_ON       = 3'd1;
  localparam logic [ModeW-1:0] MCODE_BLINK    = 3'd2;
  localparam logic [ModeW-1:0] MCODE_PEND_ON  = 3'd3;
  localparam logic [ModeW-1:0] MCODE_PEND_OFF = 3'd4;

  typedef enum logic [4:0] {
    MODE_OFF      = 5'b00001,
    MODE_ON       = 5'b00010,
    MODE_BLINK    = 5'b00100,
    MODE_PEND_ON  = 5'b01000,
    MODE_PEND_OFF = 5'b10000
  } mode_t;

  function automatic logic [ModeW-1:0] mode_code(input mode_t m);
    logic [ModeW-1:0] c;
    c = MCODE_OFF;
    unique case (m)
      MODE_OFF:      c = MCODE_OFF;
      MODE_ON:       c = MCODE_ON;
      MODE_BLINK:    c = MCODE_BLINK;
      MODE_PEND_ON:  c = MCODE_PEND_ON;
      MODE_PEND_OFF: c = MCODE_PEND_OFF;
      default:       c = MCODE_OFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/backlight_timeout_blink_controller.sv */
`default_nettype none

// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+---------------------------------
// in_      | slave     | in_tvalid / in_tready        | in_tdata: cmd, custom_ms
// out_     | master    | out_tvalid / out_tready      | out_tdata: light_on, mode
// cfg_     | write     | cfg_we                       | cfg_addr, cfg_wdata
//
// The controller state is updated at the edge that accepts the beat, and the
// result beat is registered at the same edge, into the skid register if out_
// is stalled. Sustained rate is one beat per cycle while out_tready stays high.
// A two-entry output (result register plus skid register) lets one further
// beat in while a result is stalled; in_tready drops only when both are full.
// rst_n is synchronous: the light goes dark, the mode goes off and the
// registers return to 5000 ms on time, 500 ms blink pause and a goal of four.

module backlight_timeout_blink_controller (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input beat
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // [2:0] cmd, [18:3] custom_ms, [23:19] zero
  input  wire logic [btbc_pkg::InDataW-1:0]       in_tdata,
  // Result beat
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // [0] light_on, [3:1] mode, [7:4] zero
  output      logic [btbc_pkg::OutDataW-1:0]      out_tdata,
  // Configuration writes
  input  wire logic                               cfg_we,
  input  wire logic [btbc_pkg::CfgAddrW-1:0]      cfg_addr,
  input  wire logic [btbc_pkg::CfgDataW-1:0]      cfg_wdata
);

  import btbc_pkg::*;

  // Configuration registers
  logic [MsW-1:0]   default_on_r;
  logic [MsW-1:0]   blink_pause_r;
  logic [GoalW-1:0] blink_goal_r;

  // Controller state
  mode_t             mode_r, mode_nxt;
  logic [MsW-1:0]    remaining_r, remaining_nxt;
  logic [MsW-1:0]    on_time_r, on_time_nxt;
  logic [BlinkW-1:0] blinks_r, blinks_nxt;
  logic              phase_r, phase_nxt;
  logic              stay_r, stay_nxt;
  logic              light_r, light_nxt;

  // Output register and skid register
  logic                out_valid_r;
  logic [ModeW:0]      out_data_r;
  logic                skid_valid_r;
  logic [ModeW:0]      skid_data_r;
  logic [ModeW:0]      result;

  logic            in_accept;
  logic [CmdW-1:0] cmd;
  logic [MsW-1:0]  duration;
  logic [MsW-1:0]  rem_dec;

  assign cmd      = in_tdata[CmdW-1:0];
  assign duration = in_tdata[CmdW+MsW-1:CmdW];

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_on_r  <= DefaultOnReset;
      blink_pause_r <= BlinkPauseReset;
      blink_goal_r  <= BlinkGoalReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEFAULT_ON:  default_on_r  <= cfg_wdata[MsW-1:0];
        REG_BLINK_PAUSE: blink_pause_r <= cfg_wdata[MsW-1:0];
        REG_BLINK_GOAL:  blink_goal_r  <= cfg_wdata[GoalW-1:0];
        default: ;
      endcase
    end
  end

  assign rem_dec = (remaining_r != '0) ? remaining_r - MsW'(1) : '0;

  // Next state. A blink toggle is written out once and shared by a running blink
  // and a fresh start, where the count and the phase begin from zero.
  always_comb begin
    logic [BlinkW-1:0] nb;
    logic              base_phase;
    logic              base_stay;
    logic              do_toggle;

    mode_nxt      = mode_r;
    remaining_nxt = remaining_r;
    on_time_nxt   = on_time_r;
    blinks_nxt    = blinks_r;
    phase_nxt     = phase_r;
    stay_nxt      = stay_r;
    light_nxt     = light_r;
    nb            = blinks_r + BlinkW'(1);
    base_phase    = phase_r;
    base_stay     = stay_r;
    do_toggle     = 1'b0;

    case (cmd) inside
      CMD_TICK: begin
        if (mode_r != MODE_OFF) begin
          remaining_nxt = rem_dec;
          if (rem_dec == '0) begin
            unique case (mode_r)
              MODE_PEND_ON: begin
                mode_nxt      = MODE_ON;
                remaining_nxt = on_time_r;
                light_nxt     = 1'b1;
              end
              MODE_BLINK: do_toggle = 1'b1;
              default: begin
                // Timed period over or pending off: go dark.
                mode_nxt      = MODE_OFF;
                remaining_nxt = '0;
                on_time_nxt   = default_on_r;
                blinks_nxt    = '0;
                phase_nxt     = 1'b0;
                stay_nxt      = 1'b0;
                light_nxt     = 1'b0;
              end
            endcase
          end
        end
      end
      CMD_EN_DEFAULT, CMD_EN_CUSTOM: begin
        on_time_nxt   = (cmd == CMD_EN_CUSTOM) ? duration : default_on_r;
        remaining_nxt = on_time_nxt;
        mode_nxt      = MODE_ON;
        light_nxt     = 1'b1;
      end
      CMD_BLINK_OFF, CMD_BLINK_ON: begin
        nb         = BlinkW'(1);
        base_phase = 1'b0;
        base_stay  = (cmd == CMD_BLINK_ON);
        stay_nxt   = base_stay;
        mode_nxt   = MODE_BLINK;
        do_toggle  = 1'b1;
      end
      default: ;
    endcase

    if (do_toggle) begin
      blinks_nxt    = nb;
      remaining_nxt = blink_pause_r;
      if (nb > {1'b0, blink_goal_r}) begin
        if (base_stay) begin
          on_time_nxt = default_on_r;
          mode_nxt    = MODE_PEND_ON;
        end else begin
          mode_nxt    = MODE_PEND_OFF;
        end
      end
      phase_nxt = !base_phase;
      light_nxt = !base_phase;
    end
  end

  assign result = {mode_code(mode_nxt), light_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      remaining_r <= '0;
      on_time_r   <= '0;
      blinks_r    <= '0;
      phase_r     <= 1'b0;
      stay_r      <= 1'b0;
      light_r     <= 1'b0;
    end else if (in_accept) begin
      mode_r      <= mode_nxt;
      remaining_r <= remaining_nxt;
      on_time_r   <= on_time_nxt;
      blinks_r    <= blinks_nxt;
      phase_r     <= phase_nxt;
      stay_r      <= stay_nxt;
      light_r     <= light_nxt;
    end
  end

  // Result register with skid: a beat accepted while the result register is
  // stalled parks in the skid register and moves up once the stall clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      if (in_accept) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (in_accept) begin
        skid_data_r <= result;
      end
    end else if (skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if (in_accept) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW - ModeW - 1)'(0), out_data_r};

  // The skid register only ever holds a beat behind the result register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while result register empty");

  // A beat taken during an output stall must land in the skid register.
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && in_accept) |=> skid_valid_r)
    else $error("beat accepted during stall was lost");

  // A timed on period always drives the light; off always leaves it dark.
  a_on_is_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ON) |-> light_r)
    else $error("light dark in timed on mode");

  a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_OFF) |-> (!light_r && remaining_r == '0))
    else $error("light lit or timer running in off mode");

endmodule

`default_nettype wire
